[design/lmfs_pkg.sv]
// Shared constants, command and state codes, and request and response types for the frame scanner.
`timescale 1ns / 1ps

package lmfs_pkg;

  localparam int ROWS       = 16;
  localparam int COLS       = 128;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLS);
  localparam int DIGIT_W    = 8;
  localparam int BIT_W      = $clog2(DIGIT_W);
  localparam int ROW_DIGITS = (COLS + DIGIT_W - 1) / DIGIT_W;
  localparam int DIGIT_SEL_W = COL_W - BIT_W;
  localparam int DEPTH      = ROWS * ROW_DIGITS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SEL_W      = 4;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] row;
    logic [6:0] column;
    logic       pixel_value;
  } in_req_t;

  typedef struct packed {
    logic       serial_bit;
    logic [2:0] line_bits;
    logic       upper_half_select;
    logic       latch_pulse;
  } out_rsp_t;

endpackage

[design/led_matrix_frame_scanner_core.sv]
// Top level of the LED matrix frame scanner: frame store, scan counters and output register.
//
// Usage: requests arrive on the in channel (in_valid_i / in_ready_o / in_req_i).
// A write request sets or clears one pixel, a clear request blanks the frame, and
// a refresh request yields one response on the out channel (out_valid_o /
// out_ready_i / out_rsp_o) carrying the pixel at the scan position, the row
// select lines and a latch pulse on the last column, after which the scan advances.
// The frame is held as 8-pixel digits in one RAM; each digit has a valid flag, so
// a clear only resets the flags and an unwritten digit reads as dark.
// Writes and refreshes use the registered RAM read (read in the accept cycle,
// modify in the next, or for a refresh select once the output register is free);
// a write is a read-modify-write of its digit. A refresh response passes through
// the RAM read and output registers; no request is taken until an op leaves ST_READ.
// Reset clears scan row and column, all digit valid flags and the output valid
// flag; no clearing pass is needed and requests are taken from the first cycle.
// When the receiver stalls, a waiting response holds; writes and clears still go
// through, and a further refresh is accepted and then waits on its RAM data until
// the response drains.
`timescale 1ns / 1ps

module led_matrix_frame_scanner_core
  import lmfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  state_e state_q, state_d;

  logic [ROW_W-1:0]  scan_row_q;
  logic [COL_W-1:0]  scan_col_q;
  logic [DEPTH-1:0]  valid_q;

  logic              op_refresh_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BIT_W-1:0]  bit_q;
  logic              pix_q;

  logic              out_valid_q;
  out_rsp_t          out_rsp_q;

  logic              accept;
  logic              write_ok;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              ram_re;
  logic              ram_we;
  logic [ADDR_W-1:0] raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [DIGIT_W-1:0] rd_digit;
  logic [DIGIT_W-1:0] wr_digit;
  logic              out_load;
  logic              last_col;
  logic [SEL_W-1:0]  sel_code;
  logic              clear_now;

  function automatic logic [ADDR_W-1:0] addr_f(logic [ROW_W-1:0] r,
                                               logic [DIGIT_SEL_W-1:0] d);
    logic [31:0] full;
    full = 32'(r) * 32'(ROW_DIGITS) + 32'(d);
    return full[ADDR_W-1:0];
  endfunction

  assign accept   = in_valid_i && in_ready_o;
  assign in_row   = ROW_W'(in_req_i.row);
  assign in_col   = COL_W'(in_req_i.column);
  // Drop writes that fall outside the store.
  assign write_ok = (32'(in_req_i.row) < ROWS) && (32'(in_req_i.column) < COLS);
  assign last_col = (scan_col_q == COL_W'(COLS - 1));
  assign sel_code = SEL_W'(scan_row_q) - SEL_W'(1);

  always_comb begin
    if (in_req_i.cmd == CMD_REFRESH) begin
      raddr = addr_f(scan_row_q, scan_col_q[COL_W-1:BIT_W]);
    end else begin
      raddr = addr_f(in_row, in_col[COL_W-1:BIT_W]);
    end
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    clear_now  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_req_i.cmd)
            CMD_WRITE: begin
              if (write_ok) begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end
            end
            CMD_CLEAR: begin
              clear_now = 1'b1;
            end
            CMD_REFRESH: begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (!op_refresh_q) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // Hold the read data until the output register frees up.
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the operation and its digit address at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_refresh_q <= 1'b0;
    end else if (ram_re) begin
      op_refresh_q <= (in_req_i.cmd == CMD_REFRESH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      addr_q <= raddr;
      pix_q  <= in_req_i.pixel_value;
      if (in_req_i.cmd == CMD_REFRESH) begin
        bit_q <= scan_col_q[BIT_W-1:0];
      end else begin
        bit_q <= in_col[BIT_W-1:0];
      end
    end
  end

  lmfs_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (wr_digit),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // An unwritten digit reads as dark
  assign rd_digit = valid_q[addr_q] ? ram_rdata : '0;

  always_comb begin
    wr_digit        = rd_digit;
    wr_digit[bit_q] = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_now) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // Scan position advances as each response is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      scan_col_q <= '0;
    end else if (out_load) begin
      if (last_col) begin
        scan_col_q <= '0;
        if (scan_row_q == ROW_W'(ROWS - 1)) begin
          scan_row_q <= '0;
        end else begin
          scan_row_q <= scan_row_q + ROW_W'(1);
        end
      end else begin
        scan_col_q <= scan_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q.serial_bit        <= rd_digit[bit_q];
      out_rsp_q.line_bits         <= sel_code[2:0];
      out_rsp_q.upper_half_select <= sel_code[3];
      out_rsp_q.latch_pulse       <= last_col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_latch_wraps_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.latch_pulse |-> scan_col_q == '0)
    else $error("latch pulse pending but scan column not wrapped");

  a_clear_blanks_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_req_i.cmd == CMD_CLEAR |=> valid_q == '0)
    else $error("clear request left digits marked valid");

  a_write_marks_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && !op_refresh_q |=> valid_q[$past(addr_q)])
    else $error("written digit not marked valid");
`endif

endmodule

[design/lmfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
